@@ sv/olrq_pkg.sv @@
// ----------------------------------------------------------------------------
// olrq_pkg: shared types and constants of the ordered request queue
// Payload structs, operation codes, register indexes and the command and
// status bundles between the queue controller and its datapath.
// ----------------------------------------------------------------------------
package olrq_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = 4;    // index into the entry array
  localparam int CNT_W     = 5;    // counts and positions up to MAX_NODES
  localparam int ID_W      = 4;
  localparam int STAMP_W   = 32;

  // operation codes
  localparam logic [1:0] OP_INS_REPLACE = 2'd0;
  localparam logic [1:0] OP_INS_KEEP    = 2'd1;
  localparam logic [1:0] OP_DEL_SELF    = 2'd2;
  localparam logic [1:0] OP_DEL_NEXT    = 2'd3;

  // configuration register indexes
  localparam logic CFG_SELF_ID = 1'b0;
  localparam logic CFG_SLOTS   = 1'b1;

  localparam logic [CNT_W-1:0] NONE_ID    = 5'd16;
  localparam logic [CNT_W-1:0] POS_ABSENT = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_NODES);

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_W-1:0]    node_id;
    logic [STAMP_W-1:0] stamp;
    logic               from_remote;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]   self_position;
    logic               granted;
    logic [CNT_W-1:0]   preceding_id;
    logic [CNT_W-1:0]   occupancy;
    logic               overflow;
    logic [STAMP_W-1:0] clock_now;
  } result_t;

  typedef struct packed {
    logic load_req;
    logic scan;
    logic remove_match;
    logic insert;
    logic set_ovf;
    logic drop_start;
    logic drop_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       any_match;
    logic       any_self;
    logic       full;
    logic       drop_done;
    logic       out_free;
  } status_t;

endpackage

@@ sv/lamport_ordered_request_queue_top.sv @@
// ----------------------------------------------------------------------------
// lamport_ordered_request_queue_top: timestamp-ordered request queue
// Holds up to 16 node requests sorted by lamport stamp, then node id, and
// reports this node's place and grant after every request.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall / in_data carry one request (operation,
//   node id, stamp, remote flag); a transfer happens when in_valid is high and
//   in_stall is low. the block takes one request at a time and raises in_stall
//   while it works on it.
//   output channel: out_valid / out_stall / out_data carry one result per
//   request (position, grant, preceding id, occupancy, overflow, clock).
//   config channel: cfg_valid / cfg_ready / cfg_index / cfg_data write
//   self_id (index 0) or slots (index 1); cfg_ready is always high.
//   sequence: a request is scanned, applied (insert, overflow flag or head
//   drop), scanned again and reported; a replacing insert that finds its old
//   entry first removes it and rescans, and a delete that hits drops the head
//   entries through self, or through its successor for a delete-next (the
//   head drop shifts the array by one entry per cycle).
//   reset: rst (synchronous) empties the queue, clears the clock, sets
//   self_id to 0 and slots to 1.
//   stall: a result waits in the output register while out_stall is high; the
//   block holds the next result until the register frees up.
// ----------------------------------------------------------------------------
module lamport_ordered_request_queue_top (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  olrq_pkg::req_t    in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output olrq_pkg::result_t out_data,
  // config write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data
);

  olrq_pkg::cmd_t    cmd;
  olrq_pkg::status_t status;

  // register writes never wait
  assign cfg_ready = 1'b1;

  // sequencer: scan, update, head drop, report
  olrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // sorted array, clock, config and result register
  olrq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ sv/olrq_ctrl.sv @@
// ----------------------------------------------------------------------------
// olrq_ctrl: sequencer of the ordered request queue
// Steps one request through scan, update, head drop and report.
// ----------------------------------------------------------------------------
module olrq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  olrq_pkg::status_t status,
  output olrq_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_DROP   = 3'd3;
  localparam logic [2:0] ST_FSCAN  = 3'd4;
  localparam logic [2:0] ST_REPORT = 3'd5;

  logic [2:0] state, state_next;
  logic       replaced, replaced_next;
  logic       is_insert;

  assign in_stall  = (state != ST_IDLE);
  assign is_insert = (status.op == olrq_pkg::OP_INS_REPLACE) ||
                     (status.op == olrq_pkg::OP_INS_KEEP);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    replaced_next = replaced;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req  = 1'b1;
          replaced_next = 1'b0;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_insert) begin
          priority if ((status.op == olrq_pkg::OP_INS_REPLACE) && !replaced &&
                       status.any_match) begin
            // pull the old entry out, then rescan for the new slot
            cmd.remove_match = 1'b1;
            replaced_next    = 1'b1;
            state_next       = ST_SCAN;
          end else if (status.full) begin
            cmd.set_ovf = 1'b1;
            state_next  = ST_FSCAN;
          end else begin
            cmd.insert = 1'b1;
            state_next = ST_FSCAN;
          end
        end else if (status.any_self) begin
          cmd.drop_start = 1'b1;
          state_next     = ST_DROP;
        end else begin
          state_next = ST_FSCAN;
        end
      end
      ST_DROP: begin
        if (status.drop_done) begin
          state_next = ST_FSCAN;
        end else begin
          cmd.drop_step = 1'b1;
        end
      end
      ST_FSCAN: begin
        cmd.scan   = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      replaced <= 1'b0;
    end else begin
      state    <= state_next;
      replaced <= replaced_next;
    end
  end

endmodule

@@ sv/olrq_datapath.sv @@
// ----------------------------------------------------------------------------
// olrq_datapath: sorted entry array, lamport clock and result register
// Per-entry compare flags, neighbor shifts for insert and removal, and the
// configuration registers.
// ----------------------------------------------------------------------------
module olrq_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  olrq_pkg::req_t         in_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [4:0]             cfg_data,
  input  olrq_pkg::cmd_t         cmd,
  output olrq_pkg::status_t      status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output olrq_pkg::result_t      out_data
);

  localparam int N = olrq_pkg::MAX_NODES;

  // configuration
  logic [olrq_pkg::ID_W-1:0]    self_id;
  logic [olrq_pkg::CNT_W-1:0]   slots;

  // request and clock state
  olrq_pkg::req_t               req;
  logic [olrq_pkg::STAMP_W-1:0] lamport_clock;
  logic [olrq_pkg::CNT_W-1:0]   entry_count;
  logic                         ovf;
  logic [olrq_pkg::CNT_W-1:0]   prev;
  logic [olrq_pkg::CNT_W-1:0]   drop_left;

  // entry array
  logic [olrq_pkg::ID_W-1:0]    entry_node  [N];
  logic [olrq_pkg::STAMP_W-1:0] entry_stamp [N];

  // registered per-entry flags
  logic [N-1:0] f_valid, f_match, f_self, f_gt;

  logic [N-1:0]               rm_mask, ins_mask, self_first;
  logic [olrq_pkg::IDX_W-1:0] self_idx;
  logic                       self_found;
  logic [olrq_pkg::ID_W-1:0]  prev_node;
  logic [olrq_pkg::CNT_W-1:0] self_pos;
  logic [olrq_pkg::CNT_W-1:0] drop_count;
  logic [olrq_pkg::STAMP_W-1:0] merged;
  logic                       out_free;

  // thermometer from the first matching entry upward
  assign rm_mask    = f_match | ((~f_match) + N'(1));
  // entries at or after the insertion point (array is sorted)
  assign ins_mask   = f_gt | ~f_valid;
  assign self_first = f_self & ((~f_self) + N'(1));
  assign self_found = |f_self;

  always_comb begin
    self_idx  = '0;
    prev_node = '0;
    for (int i = 0; i < N; i++) begin
      if (self_first[i]) begin
        self_idx = self_idx | olrq_pkg::IDX_W'(i);
      end
    end
    for (int i = 1; i < N; i++) begin
      if (self_first[i]) begin
        prev_node = prev_node | entry_node[i-1];
      end
    end
  end

  assign self_pos   = self_found ? {1'b0, self_idx} : olrq_pkg::POS_ABSENT;
  assign drop_count = {1'b0, self_idx} + olrq_pkg::CNT_W'(1) +
                      ((req.req_type == olrq_pkg::OP_DEL_NEXT) ?
                       olrq_pkg::CNT_W'(1) : olrq_pkg::CNT_W'(0));
  assign merged     = ((in_data.stamp > lamport_clock) ? in_data.stamp : lamport_clock) +
                      olrq_pkg::STAMP_W'(1);
  assign out_free   = !out_valid || !out_stall;

  assign status.op        = req.req_type;
  assign status.any_match = |f_match;
  assign status.any_self  = self_found;
  assign status.full      = (entry_count >= olrq_pkg::FULL_COUNT);
  assign status.drop_done = (drop_left == '0) || (entry_count == '0);
  assign status.out_free  = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id       <= '0;
      slots         <= olrq_pkg::CNT_W'(1);
      lamport_clock <= '0;
      entry_count   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          olrq_pkg::CFG_SELF_ID: self_id <= cfg_data[olrq_pkg::ID_W-1:0];
          olrq_pkg::CFG_SLOTS:   slots   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_req && in_data.from_remote) begin
        lamport_clock <= merged;
      end
      if (cmd.insert) begin
        entry_count <= entry_count + olrq_pkg::CNT_W'(1);
      end else if (cmd.remove_match || cmd.drop_step) begin
        entry_count <= entry_count - olrq_pkg::CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request, flags and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req  <= in_data;
      ovf  <= 1'b0;
      prev <= olrq_pkg::NONE_ID;
    end
    if (cmd.set_ovf) begin
      ovf <= 1'b1;
    end
    if (cmd.drop_start) begin
      prev      <= self_idx == '0 ? olrq_pkg::NONE_ID : {1'b0, prev_node};
      drop_left <= drop_count;
    end else if (cmd.drop_step) begin
      drop_left <= drop_left - olrq_pkg::CNT_W'(1);
    end
    if (cmd.scan) begin
      for (int i = 0; i < N; i++) begin
        f_valid[i] <= (olrq_pkg::CNT_W'(i) < entry_count);
        f_match[i] <= (olrq_pkg::CNT_W'(i) < entry_count) &&
                      (entry_node[i] == req.node_id);
        f_self[i]  <= (olrq_pkg::CNT_W'(i) < entry_count) &&
                      (entry_node[i] == self_id);
        f_gt[i]    <= (olrq_pkg::CNT_W'(i) < entry_count) &&
                      ((req.stamp < entry_stamp[i]) ||
                       ((req.stamp == entry_stamp[i]) && (req.node_id < entry_node[i])));
      end
    end
    if (cmd.load_out) begin
      out_data.self_position <= self_pos;
      out_data.granted       <= self_found && (self_pos < slots);
      out_data.preceding_id  <= prev;
      out_data.occupancy     <= entry_count;
      out_data.overflow      <= ovf;
      out_data.clock_now     <= lamport_clock;
    end
  end

  // entry array shifts
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (ins_mask[0]) begin
        entry_node[0]  <= req.node_id;
        entry_stamp[0] <= req.stamp;
      end
      for (int i = 1; i < N; i++) begin
        if (ins_mask[i]) begin
          if (!ins_mask[i-1]) begin
            entry_node[i]  <= req.node_id;
            entry_stamp[i] <= req.stamp;
          end else begin
            entry_node[i]  <= entry_node[i-1];
            entry_stamp[i] <= entry_stamp[i-1];
          end
        end
      end
    end else if (cmd.remove_match) begin
      for (int i = 0; i < N - 1; i++) begin
        if (rm_mask[i]) begin
          entry_node[i]  <= entry_node[i+1];
          entry_stamp[i] <= entry_stamp[i+1];
        end
      end
    end else if (cmd.drop_step) begin
      for (int i = 0; i < N - 1; i++) begin
        entry_node[i]  <= entry_node[i+1];
        entry_stamp[i] <= entry_stamp[i+1];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= olrq_pkg::FULL_COUNT)
    else $error("entry count above capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> entry_count < olrq_pkg::FULL_COUNT)
    else $error("insert into full array");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result overwritten while waiting");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop_step |-> entry_count != '0)
    else $error("head drop on empty array");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overflow) |-> out_data.occupancy == olrq_pkg::FULL_COUNT)
    else $error("overflow reported with room left");

endmodule

@@ dv/olrq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olrq_checker: result checker for the ordered request queue
// Watches the request, result and register channels, keeps its own copy of
// the sorted queue, clock and registers, predicts each result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module olrq_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  olrq_pkg::req_t    in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  olrq_pkg::result_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data,
  output int                fail_count,
  output int                outstanding
);
  import olrq_pkg::*;

  // mirror of the sorted queue, only the first q_count entries are live
  logic [ID_W-1:0]    q_node  [MAX_NODES];
  logic [STAMP_W-1:0] q_stamp [MAX_NODES];
  int                 q_count;
  logic [STAMP_W-1:0] lclock;
  logic [ID_W-1:0]    my_id;
  logic [4:0]         slot_limit;
  result_t            pending_results[$];
  result_t            want;

  function automatic int find_id(logic [ID_W-1:0] id);
    int i;
    for (i = 0; i < q_count; i++)
      if (q_node[i] == id) return i;
    return MAX_NODES;
  endfunction

  // applies one request to the mirror and returns the result it should give
  function automatic result_t apply_request(req_t r);
    result_t          res;
    int               hit;
    int               pos;
    int               ndrop;
    int               i;
    logic [CNT_W-1:0] prev;
    res  = '0;
    prev = NONE_ID;
    if (r.from_remote)
      lclock = ((r.stamp > lclock) ? r.stamp : lclock) + 32'd1;
    if (r.req_type == OP_INS_REPLACE || r.req_type == OP_INS_KEEP) begin
      hit = (r.req_type == OP_INS_REPLACE) ? find_id(r.node_id) : MAX_NODES;
      if (hit < q_count) begin
        for (i = hit; i + 1 < q_count; i++) begin
          q_node[i]  = q_node[i + 1];
          q_stamp[i] = q_stamp[i + 1];
        end
        q_count--;
      end
      if (q_count >= MAX_NODES) begin
        res.overflow = 1'b1;
      end else begin
        pos = 0;
        while (pos < q_count && !(r.stamp < q_stamp[pos] ||
               (r.stamp == q_stamp[pos] && r.node_id < q_node[pos])))
          pos++;
        for (i = q_count; i > pos; i--) begin
          q_node[i]  = q_node[i - 1];
          q_stamp[i] = q_stamp[i - 1];
        end
        q_node[pos]  = r.node_id;
        q_stamp[pos] = r.stamp;
        q_count++;
      end
    end else begin
      pos = find_id(my_id);
      if (pos < q_count) begin
        if (pos > 0) prev = {1'b0, q_node[pos - 1]};
        ndrop = pos + 1 + ((r.req_type == OP_DEL_NEXT) ? 1 : 0);
        if (ndrop > q_count) ndrop = q_count;
        for (i = 0; i + ndrop < q_count; i++) begin
          q_node[i]  = q_node[i + ndrop];
          q_stamp[i] = q_stamp[i + ndrop];
        end
        q_count -= ndrop;
      end
    end
    pos = find_id(my_id);
    res.self_position = (pos < q_count) ? CNT_W'(pos) : POS_ABSENT;
    res.granted       = (pos < q_count) && (pos < slot_limit);
    res.preceding_id  = prev;
    res.occupancy     = CNT_W'(q_count);
    res.clock_now     = lclock;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      q_count    = 0;
      lclock     = '0;
      my_id      = '0;
      slot_limit = 5'd1;
      fail_count = 0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SELF_ID) my_id = cfg_data[ID_W-1:0];
        else slot_limit = cfg_data;
      end
      if (in_valid && !in_stall)
        pending_results.insert(pending_results.size(), apply_request(in_data));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("self_position", want.self_position, out_data.self_position);
          check_field("granted",       want.granted,       out_data.granted);
          check_field("preceding_id",  want.preceding_id,  out_data.preceding_id);
          check_field("occupancy",     want.occupancy,     out_data.occupancy);
          check_field("overflow",      want.overflow,      out_data.overflow);
          check_field("clock_now",     want.clock_now,     out_data.clock_now);
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the lamport ordered request queue
// Drives requests and register writes into the block, throttles the result
// side, and reports the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;
  import olrq_pkg::*;

  // long output hold, long enough for the block to back up into its input
  localparam int LONG_HOLD  = 40;
  // settle time after the last result, above the worst request latency
  localparam int DRAIN_WAIT = 30;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  req_t        in_data;
  logic        out_valid;
  logic        out_stall;
  result_t     out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [4:0]  cfg_data;
  int          fail_count;
  int          outstanding;

  // stimulus controls; idle_on and hold_out are shared with the result-side process
  bit          idle_on;
  bit          hold_out;
  logic [31:0] stamp_base;

  lamport_ordered_request_queue_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  olrq_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard limit on the run, far above the slowest correct run
  initial begin : watchdog
    #(4_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_throttle
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        // hold results back while the sender keeps offering requests
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic req_t pack_req(logic [1:0] op, logic [3:0] id, logic [31:0] ts,
                                    logic remote);
    req_t r;
    r.req_type    = op;
    r.node_id     = id;
    r.stamp       = ts;
    r.from_remote = remote;
    return r;
  endfunction

  // random request: self id shows up often so deletes find something,
  // stamps mostly creep upward with ties, sometimes fully random or near wrap
  function automatic req_t random_req(logic [3:0] me, int del_pct);
    req_t r;
    if ($urandom_range(0, 99) < del_pct)
      r.req_type = $urandom_range(0, 1) ? OP_DEL_SELF : OP_DEL_NEXT;
    else
      r.req_type = $urandom_range(0, 1) ? OP_INS_REPLACE : OP_INS_KEEP;
    r.node_id = ($urandom_range(0, 3) == 0) ? me : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       r.stamp = $urandom;
      1:       r.stamp = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: begin
        r.stamp    = stamp_base + $urandom_range(0, 6);
        stamp_base = stamp_base + $urandom_range(0, 4);
      end
    endcase
    r.from_remote = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // one request transfer, with an optional idle gap in front
  task automatic send_req(input req_t r);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random phase under a fixed register setting; the block is idle on
  // entry and is drained again before returning
  task automatic run_phase(input logic [3:0] me, input logic [4:0] nslots, input int n,
                           input int del_pct, input bit long_hold, input bit mid_pause);
    int k;
    write_reg(CFG_SELF_ID, {1'b0, me});
    write_reg(CFG_SLOTS, nslots);
    for (k = 0; k < n; k++) begin
      if (long_hold && k == 4) hold_out = 1'b1;
      // sender pause: let everything drain mid-phase
      if (mid_pause && k == n / 2) wait_drained();
      send_req(random_req(me, del_pct));
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int i;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SELF_ID;
    cfg_data   = '0;
    idle_on    = 1'b1;
    hold_out   = 1'b0;
    stamp_base = 32'd100;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed part, this node is id 5 with three slots
    write_reg(CFG_SELF_ID, 5'd5);
    write_reg(CFG_SLOTS, 5'd3);
    // deletes on an empty queue: self absent
    send_req(pack_req(OP_DEL_SELF, 4'd5, 32'd0, 1'b0));
    send_req(pack_req(OP_DEL_NEXT, 4'd5, 32'd0, 1'b0));
    // self alone, then successor delete with no successor
    send_req(pack_req(OP_INS_KEEP, 4'd5, 32'd100, 1'b1));
    send_req(pack_req(OP_DEL_NEXT, 4'd0, 32'd0, 1'b0));
    // duplicate self entries and an equal-stamp tie broken by id
    send_req(pack_req(OP_INS_KEEP, 4'd5, 32'd100, 1'b0));
    send_req(pack_req(OP_INS_KEEP, 4'd5, 32'd50, 1'b0));
    send_req(pack_req(OP_INS_KEEP, 4'd2, 32'd50, 1'b0));
    // delete through the first self entry, preceded by node 2
    send_req(pack_req(OP_DEL_SELF, 4'd0, 32'd0, 1'b0));
    // replacing insert that finds its old entry
    send_req(pack_req(OP_INS_REPLACE, 4'd5, 32'd200, 1'b1));
    // merge with the largest stamp wraps the clock to zero
    send_req(pack_req(OP_INS_REPLACE, 4'd0, 32'hFFFF_FFFF, 1'b1));
    send_req(pack_req(OP_INS_REPLACE, 4'd15, 32'd0, 1'b0));
    // fill the queue to capacity
    for (i = 0; i < 13; i++)
      send_req(pack_req(OP_INS_KEEP, 4'((i * 7) % 16), 32'(1000 - i * 37), 1'(i % 2)));
    // full: a keeping insert is dropped, a replacing one goes through
    send_req(pack_req(OP_INS_KEEP, 4'd9, 32'd10, 1'b1));
    send_req(pack_req(OP_INS_REPLACE, 4'd15, 32'd500, 1'b0));
    // delete through self and its successor
    send_req(pack_req(OP_DEL_NEXT, 4'd0, 32'd0, 1'b0));
    wait_drained();

    // random phases across register settings, extremes first
    run_phase(4'd0,  5'd1,  110, 30, 1'b0, 1'b0);
    run_phase(4'd15, 5'd16, 110,  8, 1'b1, 1'b0);   // fills up, long output hold
    run_phase(4'd9,  5'd0,  100, 35, 1'b0, 1'b1);   // nothing granted, sender pause
    run_phase(4'd3,  5'd31, 100, 25, 1'b0, 1'b0);   // slots above capacity
    run_phase(4'($urandom_range(0, 15)), 5'($urandom_range(1, 16)), 100, 30, 1'b0, 1'b0);
    // last stretch at full rate on both sides
    idle_on = 1'b0;
    run_phase(4'($urandom_range(0, 15)), 5'($urandom_range(1, 16)), 100, 30, 1'b0, 1'b0);

    // catch any stray result after the last expected one
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
